[sv/fp32_split_two_bf16_defines.svh]
// Assertion macros shared by the fp32 to bf16 split block.
// No dependencies.
`ifndef FP32_SPLIT_TWO_BF16_DEFINES_SVH
`define FP32_SPLIT_TWO_BF16_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fsb_pkg.sv]
// Package for the fp32 to bf16 split block: payload types and constants.
// No dependencies.
package fsb_pkg;
    localparam logic [15:0] QNAN_BF16 = 16'h7FC0;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] high_part;
        logic [15:0] low_part;
        logic        last_out;
    } t_out_item;
endpackage

[sv/fsb_if.sv]
// Valid/ready channel interfaces for the split block.
// Depends on fsb_pkg.
interface fsb_in_if import fsb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fsb_out_if import fsb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/fp32_split_two_bf16.sv]
// Top level: input register, split logic, output register.
// Depends on fsb_pkg, fsb_if, fsb_split and the defines header.
//
//  channel  | dir | payload
//  s_in     | in  | value_bits[31:0], last_in
//  m_out    | out | high_part[15:0], low_part[15:0], last_out
//
// One transaction per cycle while m_out is not stalled; data passes the input reg, then the output reg.
// Each stage advances when the stage after it is empty or being drained.
// Reset clears both stage valid flags; payload is not reset.
// Output stall backs up through the stages into s_in.ready.
`include "fp32_split_two_bf16_defines.svh"
module fp32_split_two_bf16
    import fsb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    fsb_in_if.sink   s_in,
    fsb_out_if.source m_out
);
    logic      r_v1, n_v1, r_v2, n_v2;
    t_in_item  r_in;
    t_out_item r_out, w_res;
    logic      adv2, adv1;

    assign adv2 = r_v1 && (!r_v2 || m_out.ready);
    assign adv1 = !r_v1 || adv2;
    assign s_in.ready = adv1;

    fsb_split u_split (.i_item(r_in), .o_item(w_res));

    always_comb begin
        n_v1 = adv1 ? s_in.valid : r_v1;
        n_v2 = adv2 ? 1'b1 : (m_out.ready ? 1'b0 : r_v2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
        if (adv1 && s_in.valid) r_in <= s_in.data;
        if (adv2) r_out <= w_res;
    end

    assign m_out.valid = r_v2;
    assign m_out.data  = r_out;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready,
        m_out.valid, "output result dropped while stalled")
    `ASSERT_IMPL(a_nan, i_clk, i_rst_n, r_v1 && r_in.value_bits[30:23] == EXP_MAX,
        w_res.low_part == QNAN_BF16, "inf or nan input must give quiet nan low part")
    `ASSERT_NEXT(a_load, i_clk, i_rst_n, adv2, r_v2 && r_out.last_out == $past(r_in.last_in),
        "last flag not carried to output stage")
endmodule

[sv/fsb_split.sv]
// Combinational split of one fp32 word into high and rounded residual bf16 (quiet nan low part for inf or nan input).
// Depends on fsb_pkg.
module fsb_split
    import fsb_pkg::*;
(
    input  t_in_item  i_item,
    output t_out_item o_item
);
    logic [31:0] x;
    logic [15:0] low;
    logic [7:0]  eff;
    logic [3:0]  msb;
    logic [8:0]  esum;
    logic [31:0] res;
    logic [31:0] rnd;
    logic [22:0] frac;
    logic [7:0]  bexp;

    assign x   = i_item.value_bits;
    assign low = x[15:0];
    assign eff = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];

    // leading one position of the low half
    always_comb begin
        msb = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (low[k]) msb = 4'(k);
        end
    end

    assign esum = {1'b0, eff} + {5'd0, msb};
    assign bexp = 8'(esum - 9'd23);
    assign frac = 23'({7'd0, low} << (5'd23 - {1'b0, msb}));

    always_comb begin
        if (low == 16'd0) begin
            res = 32'd0;
        end else if (esum <= 9'd23) begin
            res = {x[31], 31'({15'd0, low} << (eff - 8'd1))};
        end else begin
            res = {x[31], bexp, frac};
        end
    end

    assign rnd = res + 32'h7FFF + {31'd0, res[16]};

    always_comb begin
        o_item.high_part = x[31:16];
        o_item.low_part  = (x[30:23] == EXP_MAX) ? QNAN_BF16 : rnd[31:16];
        o_item.last_out  = i_item.last_in;
    end
endmodule
